FILE: rtl/core/tccs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int UPC_W       = 5;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] ATTR_RESET = 8'h70;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [15:0] cell_entry;
	} out_item_t;

	// jump conditions of a control word
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_OUT_BUSY,
		C_NO_ACCEPT,
		C_DISPATCH,
		C_NO_WRAP,
		C_NOT_LAST,
		C_COPY_MORE,
		C_FILL_MORE,
		C_NEWLINE
	} cond_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_ZERO,
		CNT_INC
	} cnt_op_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_HOME,
		CUR_COL_ZERO,
		CUR_ROW_INC,
		CUR_COL_ADV
	} cur_op_t;

	typedef enum logic {
		RA_SRC,
		RA_INDEX
	} ra_sel_t;

	typedef enum logic [1:0] {
		WA_CNT,
		WA_CNT_M1,
		WA_CURSOR
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_BLANK_RST,
		WD_BLANK,
		WD_RDATA,
		WD_CHAR
	} wd_sel_t;

	typedef struct packed {
		cond_t   cond;
		upc_t    target;
		logic    ready;
		logic    rd_en;
		ra_sel_t ra_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		cnt_op_t cnt_op;
		cur_op_t cur_op;
		logic    out_load;
	} ctrl_t;

	typedef struct packed {
		opcode_t opcode;
		logic    need_wrap;
		logic    newline;
		logic    last_row;
		logic    copy_more;
		logic    fill_more;
		logic    out_busy;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/tccs_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module tccs_useq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire tccs_pkg::stat_t stat,
	output tccs_pkg::ctrl_t      ctrl
);
	import tccs_pkg::*;

	localparam upc_t U_EMIT      = 5'd0;
	localparam upc_t U_IDLE      = 5'd1;
	localparam upc_t U_DISP      = 5'd2;
	localparam upc_t U_PUT       = 5'd3;
	localparam upc_t U_WRAP      = 5'd4;
	localparam upc_t U_SCR_RD0   = 5'd5;
	localparam upc_t U_SCR_LOOP  = 5'd6;
	localparam upc_t U_SCR_LAST  = 5'd7;
	localparam upc_t U_SCR_FILL  = 5'd8;
	localparam upc_t U_WRITE     = 5'd9;
	localparam upc_t U_WCHAR     = 5'd10;
	localparam upc_t U_ROWINC    = 5'd11;
	localparam upc_t U_CLR       = 5'd12;
	localparam upc_t U_CLR_DONE  = 5'd13;
	localparam upc_t U_READ      = 5'd14;
	localparam upc_t U_BOOT      = 5'd15;
	localparam upc_t U_BOOT_DONE = 5'd16;

	function automatic ctrl_t ucode(input upc_t a);
		ctrl_t w;
		w = '0;
		unique case (a)
			U_EMIT: begin
				w.out_load = 1'b1;
				w.cond     = C_OUT_BUSY;
				w.target   = U_EMIT;
			end
			U_IDLE: begin
				w.ready  = 1'b1;
				w.cond   = C_NO_ACCEPT;
				w.target = U_IDLE;
			end
			U_DISP: begin
				w.cnt_op = CNT_ZERO;
				w.cond   = C_DISPATCH;
			end
			U_PUT: begin
				w.cond   = C_NO_WRAP;
				w.target = U_WRITE;
			end
			U_WRAP: begin
				w.cur_op = CUR_COL_ZERO;
				w.cond   = C_NOT_LAST;
				w.target = U_ROWINC;
			end
			U_SCR_RD0: begin
				w.rd_en  = 1'b1;
				w.ra_sel = RA_SRC;
				w.cnt_op = CNT_INC;
			end
			U_SCR_LOOP: begin
				w.rd_en  = 1'b1;
				w.ra_sel = RA_SRC;
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT_M1;
				w.wd_sel = WD_RDATA;
				w.cnt_op = CNT_INC;
				w.cond   = C_COPY_MORE;
				w.target = U_SCR_LOOP;
			end
			U_SCR_LAST: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT_M1;
				w.wd_sel = WD_RDATA;
			end
			U_SCR_FILL: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT;
				w.wd_sel = WD_BLANK;
				w.cnt_op = CNT_INC;
				w.cond   = C_FILL_MORE;
				w.target = U_SCR_FILL;
			end
			U_WRITE: begin
				w.cond   = C_NEWLINE;
				w.target = U_EMIT;
			end
			U_WCHAR: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CURSOR;
				w.wd_sel = WD_CHAR;
				w.cur_op = CUR_COL_ADV;
				w.cond   = C_ALWAYS;
				w.target = U_EMIT;
			end
			U_ROWINC: begin
				w.cur_op = CUR_ROW_INC;
				w.cond   = C_ALWAYS;
				w.target = U_WRITE;
			end
			U_CLR: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT;
				w.wd_sel = WD_BLANK;
				w.cnt_op = CNT_INC;
				w.cur_op = CUR_HOME;
				w.cond   = C_FILL_MORE;
				w.target = U_CLR;
			end
			U_CLR_DONE: begin
				w.cond   = C_ALWAYS;
				w.target = U_EMIT;
			end
			U_READ: begin
				w.rd_en  = 1'b1;
				w.ra_sel = RA_INDEX;
				w.cond   = C_ALWAYS;
				w.target = U_EMIT;
			end
			U_BOOT: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT;
				w.wd_sel = WD_BLANK_RST;
				w.cnt_op = CNT_INC;
				w.cond   = C_FILL_MORE;
				w.target = U_BOOT;
			end
			U_BOOT_DONE: begin
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic upc_t dispatch(input opcode_t op);
		upc_t t;
		unique case (op)
			OP_PUT:   t = U_PUT;
			OP_CLEAR: t = U_CLR;
			OP_READ:  t = U_READ;
			OP_NONE:  t = U_EMIT;
			default:  t = U_EMIT;
		endcase
		return t;
	endfunction

	upc_t upc_q;
	upc_t upc_next;
	logic jump;

	assign ctrl = ucode(upc_q);

	always_comb begin
		jump = 1'b0;
		unique case (ctrl.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_OUT_BUSY:  jump = stat.out_busy;
			C_NO_ACCEPT: jump = !accept;
			C_DISPATCH:  jump = 1'b1;
			C_NO_WRAP:   jump = !stat.need_wrap;
			C_NOT_LAST:  jump = !stat.last_row;
			C_COPY_MORE: jump = stat.copy_more;
			C_FILL_MORE: jump = stat.fill_more;
			C_NEWLINE:   jump = stat.newline;
			default:     jump = 1'b0;
		endcase
		priority if (ctrl.cond == C_DISPATCH) begin
			upc_next = dispatch(stat.opcode);
		end else if (jump) begin
			upc_next = ctrl.target;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_BOOT;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tccs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tccs_dpath #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tccs_pkg::ctrl_t    ctrl,
	input  wire logic               accept,
	input  wire tccs_pkg::in_item_t req_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data,
	input  wire logic               rsp_stall,
	output logic                    rsp_valid,
	output tccs_pkg::out_item_t     rsp_data,
	output tccs_pkg::stat_t         stat
);
	import tccs_pkg::*;

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
	localparam int AW         = $clog2(CELLS);
	localparam int PW         = $clog2(CELLS + 1);
	localparam int CW         = $clog2(COLUMNS + 1);
	localparam int RW         = $clog2(ROWS);

	logic [15:0]   screen_q [CELLS];
	logic [15:0]   rdata_q;
	logic [7:0]    attr_q;
	opcode_t       op_q;
	logic [7:0]    ch_q;
	logic [10:0]   idx_q;
	logic [AW-1:0] cnt_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic [PW-1:0] pos;
	logic [AW-1:0] ra;
	logic [AW-1:0] wa;
	logic [15:0]   wd;
	logic          out_busy;
	logic          idx_ok;

	assign pos      = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	assign out_busy = out_valid_q && rsp_stall;
	assign idx_ok   = 32'(idx_q) < 32'(CELLS);

	always_comb begin
		unique case (ctrl.ra_sel)
			RA_SRC:   ra = cnt_q + AW'(COLUMNS);
			RA_INDEX: ra = AW'(idx_q);
			default:  ra = cnt_q;
		endcase
		unique case (ctrl.wa_sel)
			WA_CNT:    wa = cnt_q;
			WA_CNT_M1: wa = cnt_q - 1'b1;
			WA_CURSOR: wa = AW'(pos);
			default:   wa = cnt_q;
		endcase
		unique case (ctrl.wd_sel)
			WD_BLANK_RST: wd = {ATTR_RESET, CH_SPACE};
			WD_BLANK:     wd = {attr_q, CH_SPACE};
			WD_RDATA:     wd = rdata_q;
			WD_CHAR:      wd = {attr_q, ch_q};
			default:      wd = {attr_q, CH_SPACE};
		endcase
	end

	always_comb begin
		stat.opcode    = op_q;
		stat.newline   = (ch_q == CH_NEWLINE);
		stat.need_wrap = (col_q == CW'(COLUMNS)) || (ch_q == CH_NEWLINE);
		stat.last_row  = (row_q == RW'(ROWS - 1));
		stat.copy_more = (cnt_q != AW'(COPY_CELLS - 1));
		stat.fill_more = (cnt_q != AW'(CELLS - 1));
		stat.out_busy  = out_busy;
	end

	// screen memory
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			screen_q[wa] <= wd;
		end
		if (ctrl.rd_en) begin
			rdata_q <= screen_q[ra];
		end
	end

	// transaction fields and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_data.opcode;
			ch_q  <= req_data.char_code;
			idx_q <= req_data.cell_index;
		end
		if (ctrl.out_load && !out_busy) begin
			out_q.cursor_position <= 11'(pos);
			out_q.cell_entry      <= (op_q == OP_READ && idx_ok) ? rdata_q : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			unique case (ctrl.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_ZERO: cnt_q <= '0;
				CNT_INC:  cnt_q <= cnt_q + 1'b1;
				default:  cnt_q <= cnt_q;
			endcase
			unique case (ctrl.cur_op)
				CUR_HOLD: ;
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				CUR_COL_ZERO: col_q <= '0;
				CUR_ROW_INC:  row_q <= row_q + 1'b1;
				CUR_COL_ADV: begin
					if (ch_q != 8'h00) begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
			priority if (ctrl.out_load && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= 32'(COLUMNS))
		else $error("cursor column beyond right edge");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) <= 32'(ROWS - 1))
		else $error("cursor row beyond last row");

	a_char_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en && ctrl.wa_sel == WA_CURSOR |-> 32'(pos) < 32'(CELLS))
		else $error("character write outside screen");

	a_copy_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en && ctrl.rd_en |-> wa != ra)
		else $error("scroll copy reads and writes one cell");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.out_load))
		else $error("result raised without emit step");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake               payload
// req      in         req_valid / req_stall   in_item_t  (opcode, char_code, cell_index)
// rsp      out        rsp_valid / rsp_stall   out_item_t (cursor_position, cell_entry)
// cfg      in         cfg_wr_en               cfg_wr_data (colour attribute)
//
// after reset the screen is blanked one cell a cycle, req stalled until the blanking is done
// plain character: dispatch, wrap check, write and emit before the next one is taken; read: dispatch, read, emit
// line wrap with scroll: one cell copy per cycle
// clear: its duration is bounded by the single write port of the screen memory
// a finished result waits in the rsp register while the next transaction is taken

module text_console_cursor_scroll #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire tccs_pkg::in_item_t req_data,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output tccs_pkg::out_item_t     rsp_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data
);
	import tccs_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  accept;

	assign req_stall = !ctrl.ready;
	assign accept    = req_valid && ctrl.ready;

	tccs_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tccs_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.accept      (accept),
		.req_data    (req_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.rsp_data    (rsp_data),
		.stat        (stat)
	);

endmodule

`default_nettype wire

FILE: dv/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;

	import tccs_pkg::*;

	localparam int COLS         = COLUMNS_DEF;
	localparam int LINES        = ROWS_DEF;
	localparam int CELLS        = COLS * LINES;
	localparam int RANDOM_ITEMS = 800;
	localparam int TAIL_CYCLES  = CELLS + 200;
	localparam int CYCLE_LIMIT  = 8_000_000;

	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic {
		ROW_TXN,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		in_item_t   item;
		logic       known;
		out_item_t  want;
		logic [7:0] attr;
	} dir_row_t;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      req_valid   = 1'b0;
	logic      req_stall;
	in_item_t  req_data    = '0;
	logic      rsp_valid;
	logic      rsp_stall   = 1'b0;
	out_item_t rsp_data;
	logic      cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	// console model state
	logic [15:0] screen_model [CELLS];
	int          model_col;
	int          model_row;
	logic [7:0]  model_attr;

	out_item_t pending_results [$];
	dir_row_t  directed_rows [$];

	int err_count     = 0;
	int checked_count = 0;
	int sent_count    = 0;
	int scroll_count  = 0;
	int read_count    = 0;
	int attr_writes   = 0;
	int burst_left    = 0;
	int cycle_count   = 0;

	text_console_cursor_scroll uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = {model_attr, CH_SPACE};
	endfunction

	function automatic out_item_t console_apply(input in_item_t it);
		out_item_t res;
		int        addr;
		res = '0;
		case (it.opcode)
			OP_PUT: begin
				if (model_col >= COLS || it.char_code == CH_NEWLINE) begin
					model_col = 0;
					if (model_row >= LINES - 1) begin
						model_row = LINES - 1;
						for (int i = 0; i < (LINES - 1) * COLS; i++)
							screen_model[i] = screen_model[i + COLS];
						for (int i = (LINES - 1) * COLS; i < CELLS; i++)
							screen_model[i] = {model_attr, CH_SPACE};
						scroll_count++;
					end else begin
						model_row++;
					end
				end
				if (it.char_code != CH_NEWLINE) begin
					addr = model_row * COLS + model_col;
					if (addr < CELLS)
						screen_model[addr] = {model_attr, it.char_code};
				end
				if (model_col < COLS && it.char_code != CH_NEWLINE && it.char_code != CH_NUL)
					model_col++;
			end
			OP_CLEAR: begin
				blank_screen();
				model_col = 0;
				model_row = 0;
			end
			OP_READ: begin
				read_count++;
				if (it.cell_index < CELLS)
					res.cell_entry = screen_model[it.cell_index];
			end
			default: ;
		endcase
		res.cursor_position = 11'(model_row * COLS + model_col);
		return res;
	endfunction

	function automatic dir_row_t txn_row(opcode_t op, logic [7:0] ch, logic [10:0] idx,
			logic known, logic [10:0] pos, logic [15:0] entry);
		dir_row_t r;
		r = '0;
		r.kind = ROW_TXN;
		r.item.opcode = op;
		r.item.char_code = ch;
		r.item.cell_index = idx;
		r.known = known;
		r.want.cursor_position = pos;
		r.want.cell_entry = entry;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(logic [7:0] value);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.attr = value;
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_txn(input in_item_t it);
		int gap;
		req_data <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic settle_idle();
		req_valid <= 1'b0;
		while (pending_results.size() != 0 || req_stall)
			@(negedge clk);
	endtask

	task automatic write_attr(input logic [7:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		model_attr = value;
		attr_writes++;
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** text_console_cursor_scroll: FAILED **");
		$finish;
	end

	// receiver stall pattern
	initial begin
		int mode;
		int len;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(32, 400);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: cursor_position %0d cell_entry %h",
					rsp_data.cursor_position, rsp_data.cell_entry);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (rsp_data.cursor_position !== want.cursor_position) begin
					$error("cursor_position: expected %0d, actual %0d",
						want.cursor_position, rsp_data.cursor_position);
					err_count++;
				end
				if (rsp_data.cell_entry !== want.cell_entry) begin
					$error("cell_entry: expected %h, actual %h",
						want.cell_entry, rsp_data.cell_entry);
					err_count++;
				end
			end
		end
	end

	initial begin
		dir_row_t  row;
		in_item_t  it;
		out_item_t predicted;
		int        random_sent;
		int        phase;
		int        phase_len;
		int        nl_permille;
		int        pick;
		int        sel;
		logic [7:0] attr;

		model_attr = ATTR_RESET;
		model_col = 0;
		model_row = 0;
		blank_screen();
		random_sent = 0;
		phase = 0;

		// reset state and extremes under the reset attribute, then under attributes FF, 00 and 5A
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd0, 1'b1, 11'd0, 16'h7020));
		directed_rows.push_back(txn_row(OP_READ, 8'hFF, 11'd1999, 1'b1, 11'd0, 16'h7020));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd2000, 1'b1, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, 8'hFF, 11'd2047, 1'b1, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_NONE, 8'hFF, 11'd2047, 1'b1, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_PUT, 8'h41, 11'd0, 1'b1, 11'd1, 16'h0000));
		directed_rows.push_back(txn_row(OP_PUT, CH_NUL, 11'd2047, 1'b1, 11'd1, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd0, 1'b1, 11'd1, 16'h7041));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd1, 1'b1, 11'd1, 16'h7000));
		directed_rows.push_back(txn_row(OP_PUT, CH_NEWLINE, 11'd0, 1'b1, 11'd80, 16'h0000));
		directed_rows.push_back(txn_row(OP_PUT, 8'hFF, 11'd0, 1'b1, 11'd81, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd80, 1'b1, 11'd81, 16'h70FF));
		directed_rows.push_back(txn_row(OP_CLEAR, 8'hFF, 11'd2047, 1'b1, 11'd0, 16'h0000));
		directed_rows.push_back(cfg_row(8'hFF));
		directed_rows.push_back(txn_row(OP_PUT, 8'h80, 11'd0, 1'b1, 11'd1, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd0, 1'b1, 11'd1, 16'hFF80));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd2, 1'b1, 11'd1, 16'h7020));
		directed_rows.push_back(cfg_row(8'h00));
		directed_rows.push_back(txn_row(OP_CLEAR, CH_NUL, 11'd0, 1'b1, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd1999, 1'b1, 11'd0, 16'h0020));
		directed_rows.push_back(txn_row(OP_PUT, CH_NEWLINE, 11'd0, 1'b1, 11'd80, 16'h0000));
		directed_rows.push_back(txn_row(OP_PUT, CH_NEWLINE, 11'd0, 1'b1, 11'd160, 16'h0000));
		directed_rows.push_back(txn_row(OP_PUT, 8'h7F, 11'd0, 1'b0, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_NONE, CH_NUL, 11'd0, 1'b0, 11'd0, 16'h0000));
		directed_rows.push_back(cfg_row(8'h5A));
		directed_rows.push_back(txn_row(OP_PUT, 8'h01, 11'd0, 1'b0, 11'd0, 16'h0000));
		directed_rows.push_back(txn_row(OP_READ, CH_NUL, 11'd160, 1'b0, 11'd0, 16'h0000));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				settle_idle();
				write_attr(row.attr);
			end else begin
				predicted = console_apply(row.item);
				pending_results.push_back(row.known ? row.want : predicted);
				send_txn(row.item);
			end
		end

		// random phases: mostly text with varying newline density, some reads
		while (random_sent < RANDOM_ITEMS) begin
			settle_idle();
			case (phase)
				0: attr = 8'h00;
				1: attr = 8'hFF;
				default: attr = 8'($urandom_range(0, 255));
			endcase
			write_attr(attr);
			case ($urandom_range(0, 3))
				0: nl_permille = 0;
				1: nl_permille = 30;
				2: nl_permille = 150;
				default: nl_permille = 400;
			endcase
			phase_len = $urandom_range(60, 140);
			for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
				it.char_code = 8'($urandom_range(0, 255));
				it.cell_index = 11'($urandom_range(0, 2047));
				pick = $urandom_range(0, 999);
				if (pick < 780) begin
					it.opcode = OP_PUT;
					sel = $urandom_range(0, 999);
					if (sel < nl_permille)
						it.char_code = CH_NEWLINE;
					else if (sel < nl_permille + 40)
						it.char_code = CH_NUL;
					else if (sel < nl_permille + 60)
						it.char_code = 8'hFF;
				end else if (pick < 950) begin
					it.opcode = OP_READ;
					sel = $urandom_range(0, 9);
					if (sel < 4)
						it.cell_index = 11'(model_row * COLS + $urandom_range(0, COLS - 1));
					else if (sel < 9)
						it.cell_index = 11'($urandom_range(0, CELLS - 1));
				end else if (pick < 955) begin
					it.opcode = OP_CLEAR;
				end else begin
					it.opcode = OP_NONE;
				end
				random_sent++;
				pending_results.push_back(console_apply(it));
				send_txn(it);
			end
			phase++;
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d transactions sent, %0d results checked, %0d attribute settings",
			sent_count, checked_count, attr_writes);
		$display("%0d screen scrolls and %0d cell reads over %0d random phases",
			scroll_count, read_count, phase);
		if (err_count == 0) begin
			$display("** text_console_cursor_scroll: PASSED **");
		end else begin
			$display("** text_console_cursor_scroll: FAILED **");
		end
		$finish;
	end

endmodule
